// File: sv/bsbk_pkg.sv
// Package for the bounded sorted best-k list.
// Holds operation codes, register indexes, fixed field widths and the sequencer states.
// No dependencies.
package bsbk_pkg;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int MAX_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [MAX_W-1:0] MAX_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CMP_SEC     = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAIL,
    ST_SCAN,
    ST_READ
  } st_t;

endpackage

// File: sv/bounded_sorted_best_k_list.sv
// Bounded sorted best-k list: top level with sequencer, entry RAM and shared comparator.
// Depends on bsbk_pkg, bsbk_ram and bsbk_cmp.
// Insert: tail check when full (reject there, or from idle at zero capacity), then a scan;
// read passes the read state; clear and unused codes answer from idle. Receiver cannot stall.
// Throughput: one operation at a time, busy until its result; the scan reads one entry a cycle.
// Reset (synchronous, active low) empties the list and restores the register defaults.
module bounded_sorted_best_k_list
  import bsbk_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int TAG_BITS    = 16,
  parameter int ENERGY_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [OP_W-1:0]               in_operation,
  input  logic [TAG_BITS-1:0]           in_item_tag,
  input  logic signed [ENERGY_BITS-1:0] in_energy,
  input  logic signed [ENERGY_BITS-1:0] in_secondary_energy,
  input  logic [IDX_W-1:0]              in_read_index,
  output logic                          out_valid,
  output logic                          out_accepted,
  output logic                          out_entry_valid,
  output logic [TAG_BITS-1:0]           out_entry_tag,
  output logic signed [ENERGY_BITS-1:0] out_entry_energy,
  output logic signed [ENERGY_BITS-1:0] out_entry_secondary,
  output logic [CNT_W-1:0]              out_list_count,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = TAG_BITS + 2 * ENERGY_BITS;
  localparam int LW = (CW > MAX_W) ? CW : MAX_W;
  localparam int RW = (AW > IDX_W) ? AW : IDX_W;

  st_t state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [MAX_W-1:0]             max_r;
  logic                         cmp_sec_r;
  logic [TAG_BITS-1:0]          tag_r, tag_nxt;
  logic signed [ENERGY_BITS-1:0] en_r, en_nxt;
  logic signed [ENERGY_BITS-1:0] sec_r, sec_nxt;
  logic [CW-1:0]                k_r, k_nxt;
  logic                         found_r, found_nxt;
  logic                         full_r, full_nxt;
  logic [EW-1:0]                carry_r, carry_nxt;
  logic                         rd_ok_r, rd_ok_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_acc_r, out_acc_nxt;
  logic                          out_ev_r, out_ev_nxt;
  logic [TAG_BITS-1:0]           out_tag_r, out_tag_nxt;
  logic signed [ENERGY_BITS-1:0] out_en_r, out_en_nxt;
  logic signed [ENERGY_BITS-1:0] out_sec_r, out_sec_nxt;
  logic [CNT_W-1:0]              out_cnt_r, out_cnt_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [EW-1:0]       ram_wdata, ram_rdata;
  logic                not_worse;
  logic                full_now;
  logic                emit;
  logic [CW-1:0]       k_plus1, cnt_m1, last_pos;
  logic [RW-1:0]       idx_ext;
  logic [TAG_BITS-1:0] rd_tag;
  logic signed [ENERGY_BITS-1:0] rd_en, rd_sec;

  assign rd_tag = ram_rdata[EW-1 -: TAG_BITS];
  assign rd_en  = ram_rdata[2*ENERGY_BITS-1 -: ENERGY_BITS];
  assign rd_sec = ram_rdata[ENERGY_BITS-1:0];

  bsbk_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bsbk_cmp #(.ENERGY_BITS(ENERGY_BITS)) u_cmp (
    .entry_energy    (rd_en),
    .entry_secondary (rd_sec),
    .item_energy     (en_r),
    .item_secondary  (sec_r),
    .use_secondary   (cmp_sec_r),
    .not_worse       (not_worse)
  );

  // Limit in force is the smaller of the register and the storage depth.
  assign full_now = (LW'(count_r) >= LW'(max_r)) || (count_r == CW'(DEPTH));
  assign k_plus1  = k_r + 1'b1;
  assign cnt_m1   = count_r - 1'b1;
  assign last_pos = full_r ? cnt_m1 : count_r;
  assign idx_ext  = RW'(in_read_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      max_r       <= MAX_RESET;
      cmp_sec_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      out_cnt_r   <= out_cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_ENTRIES: max_r     <= cfg_wdata[MAX_W-1:0];
          CFG_CMP_SEC:     cmp_sec_r <= cfg_wdata[0];
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r     <= tag_nxt;
    en_r      <= en_nxt;
    sec_r     <= sec_nxt;
    k_r       <= k_nxt;
    found_r   <= found_nxt;
    full_r    <= full_nxt;
    carry_r   <= carry_nxt;
    rd_ok_r   <= rd_ok_nxt;
    out_acc_r <= out_acc_nxt;
    out_ev_r  <= out_ev_nxt;
    out_tag_r <= out_tag_nxt;
    out_en_r  <= out_en_nxt;
    out_sec_r <= out_sec_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    tag_nxt       = tag_r;
    en_nxt        = en_r;
    sec_nxt       = sec_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    full_nxt      = full_r;
    carry_nxt     = carry_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_acc_nxt   = out_acc_r;
    out_ev_nxt    = out_ev_r;
    out_tag_nxt   = out_tag_r;
    out_en_nxt    = out_en_r;
    out_sec_nxt   = out_sec_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r[AW-1:0];
    ram_wdata     = carry_r;
    ram_raddr     = '0;
    emit          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (op_t'(in_operation))
            OP_INSERT: begin
              tag_nxt   = in_item_tag;
              en_nxt    = in_energy;
              sec_nxt   = in_secondary_energy;
              full_nxt  = full_now;
              found_nxt = 1'b0;
              k_nxt     = '0;
              if (full_now && (count_r == '0)) begin
                emit        = 1'b1;
                out_acc_nxt = 1'b0;
              end else if (full_now) begin
                ram_raddr = cnt_m1[AW-1:0];
                state_nxt = ST_TAIL;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_READ: begin
              ram_raddr = idx_ext[AW-1:0];
              rd_ok_nxt = (LW'(in_read_index) < LW'(count_r));
              state_nxt = ST_READ;
            end
            OP_CLEAR: begin
              count_nxt = '0;
              emit      = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_TAIL: begin
        // Reject when the tail already ranks equal or better
        if (not_worse) begin
          emit        = 1'b1;
          out_acc_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        ram_raddr = k_plus1[AW-1:0];
        ram_we    = 1'b1;
        carry_nxt = ram_rdata;
        if (!found_r) begin
          if ((k_r == count_r) || !not_worse) begin
            ram_wdata = {tag_r, en_r, sec_r};
            found_nxt = 1'b1;
          end else begin
            // Entry stays in place; hold the slot
            ram_we = 1'b0;
          end
        end
        if (k_r == last_pos) begin
          emit        = 1'b1;
          out_acc_nxt = 1'b1;
          if (!full_r) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_plus1;
        end
      end

      ST_READ: begin
        emit        = 1'b1;
        out_ev_nxt  = rd_ok_r;
        out_tag_nxt = rd_ok_r ? rd_tag : '0;
        out_en_nxt  = rd_ok_r ? rd_en : '0;
        out_sec_nxt = rd_ok_r ? rd_sec : '0;
        state_nxt   = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_cnt_nxt   = CNT_W'(count_nxt);
      if (state_r != ST_READ) begin
        out_ev_nxt  = 1'b0;
        out_tag_nxt = '0;
        out_en_nxt  = '0;
        out_sec_nxt = '0;
      end
      if (!((state_r == ST_IDLE) && (op_t'(in_operation) == OP_INSERT)) &&
          (state_r != ST_TAIL) && (state_r != ST_SCAN)) begin
        out_acc_nxt = 1'b0;
      end
    end
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_accepted        = out_acc_r;
  assign out_entry_valid     = out_ev_r;
  assign out_entry_tag       = out_tag_r;
  assign out_entry_energy    = out_en_r;
  assign out_entry_secondary = out_sec_r;
  assign out_list_count      = out_cnt_r;

endmodule

// File: sv/bsbk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsbk_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bsbk_cmp.sv
// Shared rank comparator: is a stored entry equal to or better than the new item.
// Used for the tail check and for every step of the position scan. No dependencies.
module bsbk_cmp #(
  parameter int ENERGY_BITS = 16
) (
  input  logic signed [ENERGY_BITS-1:0] entry_energy,
  input  logic signed [ENERGY_BITS-1:0] entry_secondary,
  input  logic signed [ENERGY_BITS-1:0] item_energy,
  input  logic signed [ENERGY_BITS-1:0] item_secondary,
  input  logic                          use_secondary,
  output logic                          not_worse
);

  always_comb begin
    if (entry_energy < item_energy) begin
      not_worse = 1'b1;
    end else if (entry_energy > item_energy) begin
      not_worse = 1'b0;
    end else if (!use_secondary) begin
      not_worse = 1'b1;
    end else begin
      not_worse = (entry_secondary <= item_secondary);
    end
  end

endmodule

// File: sv/bsbk_chk.sv
// Port-level checker for the bounded sorted best-k list, bound to the top level.
// Depends on bsbk_pkg and bounded_sorted_best_k_list.
module bsbk_chk
  import bsbk_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_accepted,
  input logic             out_entry_valid,
  input logic [CNT_W-1:0] out_list_count
);

  // Every result traces back to a transfer or to work in progress
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result strobe with no operation under way");

  // An accepted operation either finishes at once or holds busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted operation neither busy nor finished");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_entry_valid))
    else $error("insert acceptance and read validity together");

  // The count moves only with a result
  a_count_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(out_list_count) |-> out_valid)
    else $error("list count changed without a result");

endmodule

bind bounded_sorted_best_k_list bsbk_chk u_bsbk_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_accepted    (out_accepted),
  .out_entry_valid (out_entry_valid),
  .out_list_count  (out_list_count)
);

// File: tb/sv/bounded_sorted_best_k_list_test.sv
// Self-checking testbench for the bounded sorted best-k list: a directed table, then random
// phases under several capacity and tie-break settings, checked against a behavioural ranking.
// Depends on bsbk_pkg and bounded_sorted_best_k_list.
`timescale 1ns / 1ps

module bounded_sorted_best_k_list_test;
  import bsbk_pkg::*;

  localparam int DEPTH          = 64;
  localparam int TAG_W          = 16;
  localparam int EN_W           = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PLAN_ROWS      = 25;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [TAG_W-1:0] tag;
    logic [EN_W-1:0]  energy;
    logic [EN_W-1:0]  second;
    logic [IDX_W-1:0] index;
  } list_cmd_t;

  typedef struct packed {
    logic             accepted;
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [EN_W-1:0]  energy;
    logic [EN_W-1:0]  second;
    logic [CNT_W-1:0] count;
  } list_reply_t;

  typedef struct packed {
    logic        set_regs;
    logic [6:0]  reg_cap;
    logic        reg_cmp;
    list_cmd_t   cmd;
    logic        fixed;
    list_reply_t reply;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [OP_W-1:0]        in_operation;
  logic [TAG_W-1:0]       in_item_tag;
  logic signed [EN_W-1:0] in_energy;
  logic signed [EN_W-1:0] in_secondary_energy;
  logic [IDX_W-1:0]       in_read_index;
  logic                   out_valid;
  logic                   out_accepted;
  logic                   out_entry_valid;
  logic [TAG_W-1:0]       out_entry_tag;
  logic signed [EN_W-1:0] out_entry_energy;
  logic signed [EN_W-1:0] out_entry_secondary;
  logic [CNT_W-1:0]       out_list_count;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // behavioural copy of the list and its registers
  logic [EN_W-1:0]  kept_energy [DEPTH];
  logic [EN_W-1:0]  kept_second [DEPTH];
  logic [TAG_W-1:0] kept_tag [DEPTH];
  int               kept_count;
  logic [6:0]       capacity;
  logic             tie_by_second;

  list_reply_t pending_replies[$];
  list_reply_t oldest_reply;
  int          failures;
  int          idle_cycles;

  // expectation typed in where it is plain; zero fields mean no valid entry
  plan_row_t plan [PLAN_ROWS] = '{
    '{0, 7'd0, 0, '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0},
      1, '{0, 0, 16'h0000, 16'h0000, 16'h0000, 7'd0}},
    '{0, 7'd0, 0, '{OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63},
      1, '{0, 0, 16'h0000, 16'h0000, 16'h0000, 7'd0}},
    '{0, 7'd0, 0, '{OP_INSERT, 16'hFFFF, 16'h7FFF, 16'h8000, 6'd0},
      1, '{1, 0, 16'h0000, 16'h0000, 16'h0000, 7'd1}},
    '{0, 7'd0, 0, '{OP_INSERT, 16'h0000, 16'h8000, 16'h7FFF, 6'd0},
      1, '{1, 0, 16'h0000, 16'h0000, 16'h0000, 7'd2}},
    '{0, 7'd0, 0, '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0},
      1, '{0, 1, 16'h0000, 16'h8000, 16'h7FFF, 7'd2}},
    '{0, 7'd0, 0, '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd1},
      1, '{0, 1, 16'hFFFF, 16'h7FFF, 16'h8000, 7'd2}},
    '{0, 7'd0, 0, '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd63},
      1, '{0, 0, 16'h0000, 16'h0000, 16'h0000, 7'd2}},
    // equal energy, secondary ignored: the newcomer goes behind
    '{0, 7'd0, 0, '{OP_INSERT, 16'h0001, 16'h0000, 16'h0005, 6'd0}, 0, '0},
    '{0, 7'd0, 0, '{OP_INSERT, 16'h0002, 16'h0000, 16'hFFFB, 6'd0}, 0, '0},
    '{0, 7'd0, 0, '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd1}, 0, '0},
    '{0, 7'd0, 0, '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd2}, 0, '0},
    '{0, 7'd0, 0, '{OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 6'd0},
      1, '{0, 0, 16'h0000, 16'h0000, 16'h0000, 7'd0}},
    '{0, 7'd0, 0, '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0},
      1, '{0, 0, 16'h0000, 16'h0000, 16'h0000, 7'd0}},
    '{1, 7'd2, 1, '0, 0, '0},
    '{0, 7'd0, 0, '{OP_INSERT, 16'h000A, 16'h000A, 16'h0003, 6'd0}, 0, '0},
    '{0, 7'd0, 0, '{OP_INSERT, 16'h000B, 16'h000A, 16'h0001, 6'd0}, 0, '0},
    // full, and only equal to the tail: turned away
    '{0, 7'd0, 0, '{OP_INSERT, 16'h000C, 16'h000A, 16'h0003, 6'd0},
      1, '{0, 0, 16'h0000, 16'h0000, 16'h0000, 7'd2}},
    '{0, 7'd0, 0, '{OP_INSERT, 16'h000D, 16'h0009, 16'h7FFF, 6'd0}, 0, '0},
    '{0, 7'd0, 0, '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0}, 0, '0},
    '{0, 7'd0, 0, '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd1}, 0, '0},
    // capacity now below the count: judged against the tail, count holds
    '{1, 7'd0, 0, '0, 0, '0},
    '{0, 7'd0, 0, '{OP_INSERT, 16'h000E, 16'h8000, 16'h8000, 6'd0}, 0, '0},
    '{0, 7'd0, 0, '{OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 6'd0},
      1, '{0, 0, 16'h0000, 16'h0000, 16'h0000, 7'd0}},
    '{0, 7'd0, 0, '{OP_INSERT, 16'h000F, 16'h8000, 16'h8000, 6'd0},
      1, '{0, 0, 16'h0000, 16'h0000, 16'h0000, 7'd0}},
    '{1, 7'd127, 0, '0, 0, '0}
  };

  bounded_sorted_best_k_list #(
    .DEPTH      (DEPTH),
    .TAG_BITS   (TAG_W),
    .ENERGY_BITS(EN_W)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_item_tag        (in_item_tag),
    .in_energy          (in_energy),
    .in_secondary_energy(in_secondary_energy),
    .in_read_index      (in_read_index),
    .out_valid          (out_valid),
    .out_accepted       (out_accepted),
    .out_entry_valid    (out_entry_valid),
    .out_entry_tag      (out_entry_tag),
    .out_entry_energy   (out_entry_energy),
    .out_entry_secondary(out_entry_secondary),
    .out_list_count     (out_list_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit entry_not_worse(int pos, logic [EN_W-1:0] energy,
                                         logic [EN_W-1:0] second);
    if ($signed(kept_energy[pos]) < $signed(energy)) return 1'b1;
    if ($signed(kept_energy[pos]) > $signed(energy)) return 1'b0;
    if (!tie_by_second) return 1'b1;
    return $signed(kept_second[pos]) <= $signed(second);
  endfunction

  function automatic bit rank_insert(list_cmd_t c);
    int  limit;
    int  pos;
    int  last;
    bit  full;
    limit = (capacity < DEPTH) ? int'(capacity) : DEPTH;
    full  = kept_count >= limit;
    pos   = 0;
    if (full && (kept_count == 0 || entry_not_worse(kept_count - 1, c.energy, c.second)))
      return 1'b0;
    while (pos < kept_count && entry_not_worse(pos, c.energy, c.second)) pos++;
    // when full the tail falls off, otherwise the list grows by one
    last = full ? kept_count - 1 : kept_count;
    for (int i = last; i > pos; i--) begin
      kept_energy[i] = kept_energy[i-1];
      kept_second[i] = kept_second[i-1];
      kept_tag[i]    = kept_tag[i-1];
    end
    kept_energy[pos] = c.energy;
    kept_second[pos] = c.second;
    kept_tag[pos]    = c.tag;
    if (!full) kept_count++;
    return 1'b1;
  endfunction

  function automatic list_reply_t predict_reply(list_cmd_t c);
    list_reply_t r = '0;
    case (c.op)
      OP_INSERT: begin
        r.accepted = rank_insert(c);
      end
      OP_READ: begin
        if (c.index < kept_count) begin
          r.valid  = 1'b1;
          r.tag    = kept_tag[c.index];
          r.energy = kept_energy[c.index];
          r.second = kept_second[c.index];
        end
      end
      OP_CLEAR: begin
        kept_count = 0;
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(kept_count);
    return r;
  endfunction

  function automatic logic [EN_W-1:0] pick_energy();
    // a narrow band around zero forces ties
    if ($urandom_range(0, 1) == 0) return EN_W'($urandom_range(0, 6) - 3);
    return EN_W'($urandom);
  endfunction

  function automatic list_cmd_t random_cmd(int clear_pct);
    list_cmd_t c;
    int        pick;
    int        reach;
    pick  = $urandom_range(0, 99);
    reach = (kept_count < 63) ? kept_count + 1 : 63;
    c.tag    = TAG_W'($urandom);
    c.energy = pick_energy();
    c.second = pick_energy();
    c.index  = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, reach));
    if (pick < clear_pct) c.op = OP_CLEAR;
    else if (pick < clear_pct + 3) c.op = OP_UNUSED;
    else if (pick < 65) c.op = OP_INSERT;
    else c.op = OP_READ;
    return c;
  endfunction

  // leaves start high so that a following command goes out back to back
  task automatic send_cmd(input list_cmd_t c, input bit fixed, input list_reply_t reply);
    list_reply_t predicted;
    start               <= 1'b1;
    in_operation        <= c.op;
    in_item_tag         <= c.tag;
    in_energy           <= c.energy;
    in_secondary_energy <= c.second;
    in_read_index       <= c.index;
    do @(posedge clk); while (busy);
    predicted = predict_reply(c);
    pending_replies.push_back(fixed ? reply : predicted);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0 || busy);
  endtask

  task automatic write_config(input logic [6:0] cap, input logic cmp);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_ENTRIES;
    cfg_wdata <= CFG_DATA_W'(cap);
    @(posedge clk);
    capacity  = cap;
    cfg_index <= CFG_CMP_SEC;
    cfg_wdata <= CFG_DATA_W'(cmp);
    @(posedge clk);
    tie_by_second = cmp;
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [6:0] cap, input logic cmp, input int clear_pct,
                           input int items);
    int burst;
    drain_replies();
    write_config(cap, cmp);
    burst = $urandom_range(1, 10);
    for (int k = 0; k < items; k++) begin
      send_cmd(random_cmd(clear_pct), 1'b0, '0);
      burst--;
      if (burst == 0) begin
        if ($urandom_range(0, 15) == 0) drain_replies();
        else if ($urandom_range(0, 7) == 0) pause_sender($urandom_range(10, 24));
        else pause_sender($urandom_range(1, 5));
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 10);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // results cannot be held off: take each one on its strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $error("result with no command outstanding");
        failures++;
      end else begin
        oldest_reply = pending_replies.pop_front();
        check_field("accepted", 16'(oldest_reply.accepted), 16'(out_accepted));
        check_field("entry_valid", 16'(oldest_reply.valid), 16'(out_entry_valid));
        check_field("entry_tag", oldest_reply.tag, out_entry_tag);
        check_field("entry_energy", oldest_reply.energy, out_entry_energy);
        check_field("entry_secondary", oldest_reply.second, out_entry_secondary);
        check_field("list_count", 16'(oldest_reply.count), 16'(out_list_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n               = 1'b0;
    start               = 1'b0;
    in_operation        = OP_INSERT;
    in_item_tag         = '0;
    in_energy           = '0;
    in_secondary_energy = '0;
    in_read_index       = '0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_MAX_ENTRIES;
    cfg_wdata           = '0;
    failures            = 0;
    idle_cycles         = 0;
    kept_count          = 0;
    capacity            = MAX_RESET;
    tie_by_second       = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      kept_energy[i] = '0;
      kept_second[i] = '0;
      kept_tag[i]    = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].set_regs) begin
        drain_replies();
        write_config(plan[r].reg_cap, plan[r].reg_cmp);
      end else begin
        send_cmd(plan[r].cmd, plan[r].fixed, plan[r].reply);
      end
    end

    // fill to full depth, then shrink the capacity under the held entries
    run_phase(7'd64, 1'b0, 0, 130);
    run_phase(7'd6, 1'b1, 0, 60);
    run_phase(7'd1, 1'b0, 4, 60);
    run_phase(7'd0, 1'b1, 4, 40);
    run_phase(7'd127, 1'b1, 1, 150);
    run_phase(7'd3, 1'b0, 3, 60);
    run_phase(7'd17, 1'b1, 2, 150);

    drain_replies();
    repeat (DEPTH + 8) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bsbk_pkg.sv
sv/bsbk_ram.sv
sv/bsbk_cmp.sv
sv/bounded_sorted_best_k_list.sv
sv/bsbk_chk.sv
tb/sv/bounded_sorted_best_k_list_test.sv
